### hdl/assert_macros.svh
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TGI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tgi assertion failed");

// consequent must hold in the cycle after the antecedent
`define TGI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgi assertion failed");

`endif

### hdl/tgi_pkg.sv
// shared types, widths and codes of the trilinear grid interpolator
// no dependencies
`timescale 1ns / 1ps

package tgi_pkg;

    localparam int ADDR_W     = 15;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 32;
    localparam int INV_W      = 24;
    localparam int SIZE_W     = 6;
    localparam int WT_W       = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_CORNERS = 8;
    localparam int DEF_MAX_SIZE = 32;

    localparam logic [WT_W-1:0]   ONE_Q16    = 17'h10000;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
    localparam logic [INV_W-1:0]  INV_RESET  = 24'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPC = 3'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef struct packed {
        logic [WT_W-1:0] wx;
        logic [WT_W-1:0] wy;
        logic [WT_W-1:0] wz;
    } t_weights;

    function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] raw,
                                                     input int max_size);
        logic [SIZE_W-1:0] res;
        if (raw < SIZE_W'(2)) begin
            res = SIZE_W'(2);
        end else if (int'(raw) > max_size) begin
            res = SIZE_W'(max_size);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

### hdl/tgi_intf.sv
// input and result channels of the trilinear grid interpolator
// depends on tgi_pkg
`timescale 1ns / 1ps

interface tgi_in_if;
    import tgi_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [ADDR_W-1:0]       grid_index;
    logic signed [DATA_W-1:0] sample_value;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_z;

    modport source (output valid, kind, grid_index, sample_value, pos_x, pos_y, pos_z,
                    input ready);
    modport sink (input valid, kind, grid_index, sample_value, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface tgi_out_if;
    import tgi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] interp_value;

    modport source (output valid, interp_value, input ready);
    modport sink (input valid, interp_value, output ready);
endinterface

### hdl/tgi_ram.sv
// generic single write port, single read port ram with registered read
// depends on tgi_pkg for default sizes
`timescale 1ns / 1ps

module tgi_ram #(
    parameter int WIDTH = tgi_pkg::DATA_W,
    parameter int DEPTH = tgi_pkg::DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/tgi_locate.sv
// splits one coordinate into cell index and weight over two stages
// depends on tgi_pkg
`timescale 1ns / 1ps

module tgi_locate #(
    parameter int CELL_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tgi_pkg::POS_W-1:0]  i_pos,
    input  logic [tgi_pkg::INV_W-1:0]  i_inv,
    input  logic [tgi_pkg::SIZE_W-1:0] i_size,
    output logic [CELL_W-1:0]          o_cell,
    output logic [tgi_pkg::WT_W-1:0]   o_wt
);
    import tgi_pkg::*;

    localparam int PROD_W = POS_W + INV_W;
    localparam int K_W    = PROD_W - 32;

    logic [PROD_W-1:0] w_prod;
    logic [K_W-1:0]    r_k;
    logic [15:0]       r_frac;
    logic [K_W-1:0]    w_last;
    logic [CELL_W-1:0] r_cell;
    logic [WT_W-1:0]   r_wt;

    assign w_prod = PROD_W'(i_pos) * PROD_W'(i_inv);
    assign w_last = K_W'(i_size) - K_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k    <= w_prod[PROD_W-1:32];
            r_frac <= w_prod[31:16];
            if (r_k >= w_last) begin
                r_cell <= CELL_W'(i_size - SIZE_W'(2));
                r_wt   <= ONE_Q16;
            end else begin
                r_cell <= r_k[CELL_W-1:0];
                r_wt   <= {1'b0, r_frac};
            end
        end
    end

    assign o_cell = r_cell;
    assign o_wt   = r_wt;
endmodule

### hdl/tgi_blend.sv
// weighted blend of the eight corner samples, six pipeline stages
// depends on tgi_pkg
`timescale 1ns / 1ps

module tgi_blend (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  tgi_pkg::t_weights          i_wt,
    input  tgi_pkg::t_sample           i_sample [tgi_pkg::NUM_CORNERS],
    output logic signed [tgi_pkg::DATA_W-1:0] o_value
);
    import tgi_pkg::*;

    localparam int PAIR_W = 33;
    localparam int TERM_W = PAIR_W + 1 + DATA_W;
    localparam int ACC_W  = TERM_W + 2;
    localparam int P_W    = 49;
    localparam int TP_W   = P_W + WT_W + 1;
    localparam int TOT_W  = TP_W + 1;

    logic [PAIR_W-1:0]       r_pair [4];
    logic [WT_W-1:0]         r_wz5, r_wz6, r_wz7, r_wz8;
    logic signed [TERM_W-1:0] r_term [NUM_CORNERS];
    logic signed [ACC_W-1:0]  r_acc [2];
    logic signed [P_W-1:0]    r_p [2];
    logic signed [TP_W-1:0]   r_t0, r_t1;
    logic signed [DATA_W-1:0] r_value;

    logic [WT_W-1:0]          w_wx [2];
    logic [WT_W-1:0]          w_wy [2];
    logic signed [ACC_W-1:0]  w_adj [2];
    logic signed [TOT_W-1:0]  w_tot, w_tot_adj;

    assign w_wx[0] = ONE_Q16 - i_wt.wx;
    assign w_wx[1] = i_wt.wx;
    assign w_wy[0] = ONE_Q16 - i_wt.wy;
    assign w_wy[1] = i_wt.wy;

    always_comb begin
        for (int z = 0; z < 2; z++) begin
            w_adj[z] = r_acc[z] + (r_acc[z][ACC_W-1] ? ACC_W'(16'hFFFF) : ACC_W'(0));
        end
    end

    assign w_tot     = TOT_W'(r_t0) + TOT_W'(r_t1);
    assign w_tot_adj = w_tot + (w_tot[TOT_W-1] ? TOT_W'(32'hFFFF_FFFF) : TOT_W'(0));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_pair[j] <= PAIR_W'(34'(w_wx[j % 2]) * 34'(w_wy[j / 2]));
            end
            r_wz5 <= i_wt.wz;
            for (int c = 0; c < NUM_CORNERS; c++) begin
                r_term[c] <= TERM_W'($signed({1'b0, r_pair[c % 4]}) * i_sample[c]);
            end
            r_wz6 <= r_wz5;
            for (int z = 0; z < 2; z++) begin
                r_acc[z] <= ACC_W'(r_term[4*z]) + ACC_W'(r_term[4*z+1])
                          + ACC_W'(r_term[4*z+2]) + ACC_W'(r_term[4*z+3]);
                r_p[z]   <= w_adj[z][16 +: P_W];
            end
            r_wz7 <= r_wz6;
            r_wz8 <= r_wz7;
            r_t0 <= TP_W'(r_p[0] * $signed({1'b0, ONE_Q16 - r_wz8}));
            r_t1 <= TP_W'(r_p[1] * $signed({1'b0, r_wz8}));
            r_value <= w_tot_adj[32 +: DATA_W];
        end
    end

    assign o_value = r_value;
endmodule

### hdl/trilinear_grid_interpolator.sv
// top level of the trilinear grid interpolator
// depends on tgi_pkg, tgi_intf, tgi_ram, tgi_locate, tgi_blend
// Usage:
// i_item carries words of two kinds. kind 0 stores sample_value at grid_index
// (x fastest, then y, then z) and gives no result. kind 1 is a query at
// (pos_x, pos_y, pos_z) in Q16.16 and gives one word on o_result.
// Grid sizes and inverse spacing are written through i_cfg_we / i_cfg_index /
// i_cfg_data while no word is in flight.
// Throughput: one word per cycle of either kind, back to back, unless o_result
// stalls. The grid is held in eight copies of one ram, written together and
// read at the eight corners of the cell, so every corner arrives in the same
// cycle. A query goes through the input, locate, base address, ram read and
// blend stages. A query placed right after a write sees the written sample.
// Reset clears the pipeline valid bits and loads the register defaults
// (sizes 32, spacing 1.0); grid contents stay undefined until written.
// When o_result is stalled the whole pipeline holds and i_item.ready drops
// in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps

module trilinear_grid_interpolator #(
    parameter int MAX_SIZE_X = tgi_pkg::DEF_MAX_SIZE,
    parameter int MAX_SIZE_Y = tgi_pkg::DEF_MAX_SIZE,
    parameter int MAX_SIZE_Z = tgi_pkg::DEF_MAX_SIZE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tgi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tgi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tgi_in_if.sink                         i_item,
    tgi_out_if.source                      o_result
);
    import tgi_pkg::*;

    localparam int CX_W = $clog2(MAX_SIZE_X);
    localparam int CY_W = $clog2(MAX_SIZE_Y);
    localparam int CZ_W = $clog2(MAX_SIZE_Z);
    localparam int LAST = 10;

    logic [SIZE_W-1:0]   r_cfg_sx, r_cfg_sy, r_cfg_sz;
    logic [INV_W-1:0]    r_inv;
    logic [SIZE_W-1:0]   r_sx, r_sy, r_sz;
    logic [2*SIZE_W-1:0] r_sxy;

    logic                w_en;
    logic                r_vld [1:4];
    logic                r_kind [1:4];
    logic [ADDR_W-1:0]   r_widx [1:4];
    t_sample             r_wdat [1:4];
    logic [POS_W-1:0]    r_px, r_py, r_pz;
    logic                r_qv [5:LAST];

    logic [CX_W-1:0]     w_cx;
    logic [CY_W-1:0]     w_cy;
    logic [CZ_W-1:0]     w_cz;
    logic [WT_W-1:0]     w_fx, w_fy, w_fz;
    logic [31:0]         w_base_full;
    logic [ADDR_W-1:0]   r_base;
    t_weights            r_wt;

    logic                w_we;
    logic [ADDR_W-1:0]   w_raddr [NUM_CORNERS];
    t_sample             w_sample [NUM_CORNERS];

    assign w_en         = !r_qv[LAST] || o_result.ready;
    assign i_item.ready = w_en;
    assign o_result.valid = r_qv[LAST];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sx <= SIZE_RESET;
            r_cfg_sy <= SIZE_RESET;
            r_cfg_sz <= SIZE_RESET;
            r_inv    <= INV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIZE_X:  r_cfg_sx <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:  r_cfg_sy <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:  r_cfg_sz <= i_cfg_data[SIZE_W-1:0];
                CFG_INV_SPC: r_inv    <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx  <= size_clamp(r_cfg_sx, MAX_SIZE_X);
        r_sy  <= size_clamp(r_cfg_sy, MAX_SIZE_Y);
        r_sz  <= size_clamp(r_cfg_sz, MAX_SIZE_Z);
        r_sxy <= (2*SIZE_W)'(r_sx) * (2*SIZE_W)'(r_sy);
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 4; s++) r_vld[s] <= 1'b0;
            for (int s = 5; s <= LAST; s++) r_qv[s] <= 1'b0;
        end else if (w_en) begin
            r_vld[1] <= i_item.valid;
            for (int s = 2; s <= 4; s++) r_vld[s] <= r_vld[s-1];
            r_qv[5] <= r_vld[4] && (r_kind[4] == KIND_QUERY);
            for (int s = 6; s <= LAST; s++) r_qv[s] <= r_qv[s-1];
        end
    end

    // word payload through the address stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind[1] <= i_item.kind;
            r_widx[1] <= i_item.grid_index;
            r_wdat[1] <= i_item.sample_value;
            r_px      <= i_item.pos_x;
            r_py      <= i_item.pos_y;
            r_pz      <= i_item.pos_z;
            for (int s = 2; s <= 4; s++) begin
                r_kind[s] <= r_kind[s-1];
                r_widx[s] <= r_widx[s-1];
                r_wdat[s] <= r_wdat[s-1];
            end
            r_base <= w_base_full[ADDR_W-1:0];
            r_wt   <= '{wx: w_fx, wy: w_fy, wz: w_fz};
        end
    end

    tgi_locate #(.CELL_W(CX_W)) u_loc_x (
        .i_clk(i_clk), .i_en(w_en), .i_pos(r_px), .i_inv(r_inv), .i_size(r_sx),
        .o_cell(w_cx), .o_wt(w_fx)
    );
    tgi_locate #(.CELL_W(CY_W)) u_loc_y (
        .i_clk(i_clk), .i_en(w_en), .i_pos(r_py), .i_inv(r_inv), .i_size(r_sy),
        .o_cell(w_cy), .o_wt(w_fy)
    );
    tgi_locate #(.CELL_W(CZ_W)) u_loc_z (
        .i_clk(i_clk), .i_en(w_en), .i_pos(r_pz), .i_inv(r_inv), .i_size(r_sz),
        .o_cell(w_cz), .o_wt(w_fz)
    );

    assign w_base_full = 32'(w_cx) + 32'(w_cy) * 32'(r_sx) + 32'(w_cz) * 32'(r_sxy);

    assign w_we = w_en && r_vld[4] && (r_kind[4] == KIND_WRITE);

    // one copy of the grid per corner
    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_bank
        assign w_raddr[c] = r_base + ADDR_W'(c % 2)
                          + (((c / 2) % 2) == 1 ? ADDR_W'(r_sx) : ADDR_W'(0))
                          + ((c / 4) == 1 ? ADDR_W'(r_sxy) : ADDR_W'(0));

        tgi_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we),
            .i_waddr(r_widx[4]),
            .i_wdata(r_wdat[4]),
            .i_re   (w_en),
            .i_raddr(w_raddr[c]),
            .o_rdata(w_sample[c])
        );
    end

    tgi_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_wt    (r_wt),
        .i_sample(w_sample),
        .o_value (o_result.interp_value)
    );
endmodule

### hdl/tgi_checker.sv
// port level checks of the trilinear grid interpolator, bound to the top
// depends on assert_macros.svh and trilinear_grid_interpolator
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgi_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value
);
    `TGI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `TGI_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value))
    `TGI_ASSERT(a_ready_stall, i_clk, i_rst_n, i_in_ready == (!i_out_valid || i_out_ready))
    `TGI_ASSERT(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n) |-> !i_out_valid)
endmodule

bind trilinear_grid_interpolator tgi_port_checker u_tgi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_out_value(o_result.interp_value)
);

### verif/tgi_checker.sv
// predicts the result of every query seen on the item channel and compares it
// depends on tgi_pkg and the channel interfaces in tgi_intf
`timescale 1ns / 1ps

module tgi_checker
    import tgi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tgi_in_if                     i_item,
    tgi_out_if                    i_result,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct {
        int unsigned idx;
        longint      wt;
    } t_axis;

    localparam int MAX_SIZE_X_C = DEF_MAX_SIZE;
    localparam int MAX_SIZE_Y_C = DEF_MAX_SIZE;
    localparam int MAX_SIZE_Z_C = DEF_MAX_SIZE;

    logic [DATA_W-1:0] grid_copy [DEPTH];
    logic [SIZE_W-1:0] size_x, size_y, size_z;
    logic [INV_W-1:0]  inv_spacing;
    logic [DATA_W-1:0] blend_q[$];
    int                fails;
    int                checked;

    function automatic int unsigned axis_size(input logic [SIZE_W-1:0] raw, input int top);
        int unsigned n;
        n = raw;
        if (n < 2) n = 2;
        if (n > top) n = top;
        return n;
    endfunction

    function automatic t_axis split_axis(input logic [POS_W-1:0] pos, input int unsigned n);
        logic [63:0] scaled;
        logic [63:0] k;
        t_axis       a;
        scaled = (64'(pos) * 64'(inv_spacing)) >> 16;
        k = scaled >> 16;
        if (k >= 64'(n - 1)) begin
            a.idx = n - 2;
            a.wt = 65536;
        end else begin
            a.idx = k[31:0];
            a.wt = longint'(scaled[15:0]);
        end
        return a;
    endfunction

    function automatic longint grid_at(input int unsigned addr);
        return longint'($signed(grid_copy[addr % DEPTH]));
    endfunction

    function automatic longint plane_sum(input int unsigned base, input int unsigned nx,
                                         input longint fx, input longint fy);
        longint acc;
        acc = (65536 - fx) * (65536 - fy) * grid_at(base);
        acc += fx * (65536 - fy) * grid_at(base + 1);
        acc += (65536 - fx) * fy * grid_at(base + nx);
        acc += fx * fy * grid_at(base + nx + 1);
        return acc / 65536;
    endfunction

    function automatic logic [DATA_W-1:0] trilinear(input logic [POS_W-1:0] px,
                                                    input logic [POS_W-1:0] py,
                                                    input logic [POS_W-1:0] pz);
        int unsigned nx, ny, nz, base0;
        t_axis       ax, ay, az;
        longint      p0, p1, total;
        nx = axis_size(size_x, MAX_SIZE_X_C);
        ny = axis_size(size_y, MAX_SIZE_Y_C);
        nz = axis_size(size_z, MAX_SIZE_Z_C);
        ax = split_axis(px, nx);
        ay = split_axis(py, ny);
        az = split_axis(pz, nz);
        base0 = ax.idx + ay.idx * nx + az.idx * nx * ny;
        p0 = plane_sum(base0, nx, ax.wt, ay.wt);
        p1 = plane_sum(base0 + nx * ny, nx, ax.wt, ay.wt);
        total = (p0 * (65536 - az.wt) + p1 * az.wt) / 64'sh1_0000_0000;
        return total[31:0];
    endfunction

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            size_x <= SIZE_RESET;
            size_y <= SIZE_RESET;
            size_z <= SIZE_RESET;
            inv_spacing <= INV_RESET;
            blend_q.delete();
            fails = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE_X:  size_x <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Y:  size_y <= i_cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Z:  size_z <= i_cfg_data[SIZE_W-1:0];
                    CFG_INV_SPC: inv_spacing <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.kind == KIND_WRITE) begin
                    grid_copy[i_item.grid_index] = i_item.sample_value;
                end else begin
                    blend_q.push_back(trilinear(i_item.pos_x, i_item.pos_y, i_item.pos_z));
                end
            end
            if (i_result.valid && i_result.ready) begin
                checked++;
                if (blend_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result word %h", i_result.interp_value);
                end else begin
                    want = blend_q.pop_front();
                    if (i_result.interp_value !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("interp_value mismatch: expected %h got %h",
                                     want, i_result.interp_value);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= blend_q.size();
        o_checked <= checked;
    end

endmodule

### verif/tb.sv
// stimulus and verdict for the trilinear grid interpolator
// depends on tgi_pkg, tgi_intf, tgi_checker and the block itself
`timescale 1ns / 1ps

module tb;
    import tgi_pkg::*;

    typedef struct {
        logic [SIZE_W-1:0] sx, sy, sz;
        logic [INV_W-1:0]  inv;
    } t_setting;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SIZE_X;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tgi_in_if  item_ch ();
    tgi_out_if result_ch ();

    int fail_count, pending, checked;
    int n_words, n_queries, n_settings;
    int hold_cycles;
    bit quiet;
    bit grid_written [DEPTH];
    int unsigned nx, ny, nz;
    logic [INV_W-1:0] inv_cur;

    trilinear_grid_interpolator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_item(item_ch.sink), .o_result(result_ch.source)
    );

    tgi_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_item(item_ch), .i_result(result_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int unsigned clamp_axis(input logic [SIZE_W-1:0] raw);
        int unsigned n;
        n = raw;
        if (n < 2) n = 2;
        if (n > DEF_MAX_SIZE) n = DEF_MAX_SIZE;
        return n;
    endfunction

    function automatic int unsigned cell_of(input logic [POS_W-1:0] pos, input int unsigned n);
        logic [63:0] k;
        k = ((64'(pos) * 64'(inv_cur)) >> 16) >> 16;
        if (k >= 64'(n - 1)) return n - 2;
        return k[31:0];
    endfunction

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_pos(input int unsigned n);
        logic [63:0] lim;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h0;
            default: begin
                if (inv_cur == 0) return $urandom;
                lim = (64'(n) << 32) / 64'(inv_cur);
                if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
                return $urandom_range(0, lim[31:0]);
            end
        endcase
    endfunction

    task automatic send_word(input logic kind, input logic [ADDR_W-1:0] idx,
                             input logic [DATA_W-1:0] val, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= kind;
        item_ch.grid_index <= idx;
        item_ch.sample_value <= val;
        item_ch.pos_x <= px;
        item_ch.pos_y <= py;
        item_ch.pos_z <= pz;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        n_words++;
        if (kind == KIND_WRITE) grid_written[idx] = 1'b1;
        else n_queries++;
    endtask

    task automatic store_sample(input logic [ADDR_W-1:0] idx, input logic [DATA_W-1:0] val);
        send_word(KIND_WRITE, idx, val, $urandom, $urandom, $urandom);
    endtask

    // fills any unwritten corner of the addressed cell, then queries
    task automatic query_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [POS_W-1:0] pz);
        int unsigned base, a;
        base = cell_of(px, nx) + cell_of(py, ny) * nx + cell_of(pz, nz) * nx * ny;
        for (int c = 0; c < NUM_CORNERS; c++) begin
            a = (base + ((c & 1) ? 1 : 0) + ((c & 2) ? nx : 0) + ((c & 4) ? nx * ny : 0))
                % DEPTH;
            if (!grid_written[a]) store_sample(ADDR_W'(a), rand_sample());
        end
        send_word(KIND_QUERY, ADDR_W'($urandom), $urandom, px, py, pz);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (14) @(posedge i_clk);
    endtask

    task automatic load_setting(input t_setting s);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  regs [4];
        vals = '{CFG_DATA_W'(s.sx), CFG_DATA_W'(s.sy), CFG_DATA_W'(s.sz), s.inv};
        regs = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z, CFG_INV_SPC};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        nx = clamp_axis(s.sx);
        ny = clamp_axis(s.sy);
        nz = clamp_axis(s.sz);
        inv_cur = s.inv;
        n_settings++;
    endtask

    task automatic random_words(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 1))
                    store_sample(ADDR_W'($urandom_range(0, nx * ny * nz - 1)),
                                 rand_sample());
                else
                    store_sample(ADDR_W'($urandom), rand_sample());
            end else begin
                query_at(rand_pos(nx), rand_pos(ny), rand_pos(nz));
            end
            if (i == count / 2 && n_settings == 2) hold_cycles = 300;
        end
    endtask

    initial begin
        t_setting plan [6];
        plan[0] = '{6'd2, 6'd2, 6'd2, 24'h01_0000};
        plan[1] = '{6'd0, 6'd1, 6'd63, 24'hFF_FFFF};
        plan[2] = '{6'd5, 6'd7, 6'd3, 24'h00_8000};
        plan[3] = '{6'd32, 6'd32, 6'd32, 24'h00_0000};
        plan[4] = '{6'd17, 6'd2, 6'd9, 24'h01_8000};
        plan[5] = '{6'd3, 6'd4, 6'd5, 24'h02_AAAA};
        n_words = 0;
        n_queries = 0;
        n_settings = 1;
        hold_cycles = 0;
        quiet = 1'b0;
        nx = 32;
        ny = 32;
        nz = 32;
        inv_cur = INV_RESET;
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_WRITE;
        item_ch.grid_index = '0;
        item_ch.sample_value = '0;
        item_ch.pos_x = '0;
        item_ch.pos_y = '0;
        item_ch.pos_z = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of index, sample and position at reset settings
        store_sample(15'h7FFF, 32'h8000_0000);
        store_sample(15'h0000, 32'h7FFF_FFFF);
        store_sample(15'h5555, 32'h5555_5555);
        store_sample(15'h2AAA, 32'hAAAA_AAAA);
        query_at(32'h0, 32'h0, 32'h0);
        query_at(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query_at(32'h0001_8000, 32'h0000_4000, 32'h0002_C000);
        query_at(32'h001E_FFFF, 32'h001F_0000, 32'h001D_0001);
        query_at(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF);
        random_words(60);
        drain();

        foreach (plan[p]) begin
            quiet = (p == 5);
            load_setting(plan[p]);
            query_at(32'h0, 32'hFFFF_FFFF, 32'h0000_8000);
            random_words(100);
            drain();
        end

        $display("%0d words sent, %0d of them queries, %0d results checked",
                 n_words, n_queries, checked);
        $display("%0d register settings, incl. clamped sizes and zero/max spacing",
                 n_settings);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
